// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`else

`define ASSERT_NEVER(lbl, ck, rn, expr)

`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/vnr_pkg.sv =====
// Types and constants of the vector norm reducer.
`default_nettype none

package vnr_pkg;

    localparam int SAMPLE_W = 24;
    localparam int SQUARE_W = 2 * SAMPLE_W;
    localparam int ACC_W    = 64;
    localparam int VALUE_W  = 40;
    localparam int MODE_W   = 3;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int STEP_W   = $clog2(ROOT_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_L1   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_L2   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd4;

    localparam logic [ACC_W-1:0] L1_LIMIT = 64'h0000_007F_FFFF_FFFF;

    typedef struct packed {
        logic             is_root;
        logic [ACC_W-1:0] acc;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROOT,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/vnr_front.sv =====
// Front end: accepts elements, squares them and folds them into the accumulator.
`default_nettype none

module vnr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [vnr_pkg::MODE_W-1:0]   mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [vnr_pkg::SAMPLE_W-1:0] sample,
    input  logic                         last,
    input  vnr_pkg::q_status_t           q_status,
    output logic                         push,
    output vnr_pkg::job_t                job
);
    import vnr_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0]   s1_x_reg;
    logic [SAMPLE_W-1:0]   s1_ax_reg;
    logic [SQUARE_W-1:0]   s1_sq_reg;
    logic                  s1_last_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  first_reg;

    logic [SAMPLE_W-1:0]   ax_c;
    logic [SQUARE_W-1:0]   sq_c;
    logic                  fold;
    logic                  take;
    logic [ACC_W-1:0]      base;
    logic [ACC_W-1:0]      x64;
    logic [ACC_W-1:0]      ax64;
    logic [ACC_W-1:0]      base_sat;
    logic [VALUE_W:0]      sum_l1;
    logic [ACC_W:0]        sum_l2;

    assign ax_c = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + 1'b1) : sample;
    assign sq_c = SQUARE_W'(ax_c) * SQUARE_W'(ax_c);

    assign fold     = s1_valid_reg && (!s1_last_reg || !q_status.full);
    assign in_ready = !s1_valid_reg || fold;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fold)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign base     = first_reg ? '0 : acc_reg;
    assign x64      = {{(ACC_W-SAMPLE_W){s1_x_reg[SAMPLE_W-1]}}, s1_x_reg};
    assign ax64     = {{(ACC_W-SAMPLE_W){1'b0}}, s1_ax_reg};
    assign base_sat = (base > L1_LIMIT) ? L1_LIMIT : base;
    assign sum_l1   = {1'b0, base_sat[VALUE_W-1:0]}
                    + {{(VALUE_W+1-SAMPLE_W){1'b0}}, s1_ax_reg};
    assign sum_l2   = {1'b0, base} + {{(ACC_W+1-SQUARE_W){1'b0}}, s1_sq_reg};

    always_comb
    begin
        unique case (mode)
            MODE_L1:
            begin
                if ({{(ACC_W-VALUE_W-1){1'b0}}, sum_l1} > L1_LIMIT)
                begin
                    acc_next = L1_LIMIT;
                end
                else
                begin
                    acc_next = {{(ACC_W-VALUE_W-1){1'b0}}, sum_l1};
                end
            end
            MODE_L2:
            begin
                acc_next = sum_l2[ACC_W] ? '1 : sum_l2[ACC_W-1:0];
            end
            MODE_LINF:
            begin
                acc_next = (first_reg || (ax64 > base)) ? ax64 : base;
            end
            MODE_MIN:
            begin
                acc_next = (first_reg || ($signed(x64) < $signed(base))) ? x64 : base;
            end
            MODE_MAX:
            begin
                acc_next = (first_reg || ($signed(x64) > $signed(base))) ? x64 : base;
            end
            default:
            begin
                acc_next = '0;
            end
        endcase
    end

    assign push        = fold && s1_last_reg;
    assign job.is_root = (mode == MODE_L2);
    assign job.acc     = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            first_reg    <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (fold)
            begin
                acc_reg   <= acc_next;
                first_reg <= s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_x_reg    <= sample;
            s1_ax_reg   <= ax_c;
            s1_sq_reg   <= sq_c;
            s1_last_reg <= last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vnr_queue.sv =====
// Short queue of finished vector jobs between front and back end.
`default_nettype none

module vnr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vnr_pkg::job_t      push_job,
    input  logic               pop,
    output vnr_pkg::job_t      pop_job,
    output vnr_pkg::q_status_t q_status
);
    import vnr_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_job        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vnr_back.sv =====
// Back end: integer square root unit and output register.
`default_nettype none

module vnr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vnr_pkg::job_t              job,
    input  vnr_pkg::q_status_t         q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [vnr_pkg::VALUE_W-1:0] value
);
    import vnr_pkg::*;

    back_state_t        state_reg, state_next;
    logic [ACC_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               out_valid_reg;

    logic               out_free;
    logic               load_out;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   trial;

    assign out_free  = !out_valid_reg || out_ready;
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[ACC_W-1:ACC_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        value_next = value_reg;
        load_out   = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (job.is_root)
                    begin
                        pop        = 1'b1;
                        rad_next   = job.acc;
                        rem_next   = '0;
                        root_next  = '0;
                        step_next  = STEP_W'(ROOT_W - 1);
                        state_next = B_ROOT;
                    end
                    else if (out_free)
                    begin
                        pop        = 1'b1;
                        value_next = job.acc[VALUE_W-1:0];
                        load_out   = 1'b1;
                    end
                end
            end
            B_ROOT:
            begin
                rad_next = {rad_reg[ACC_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    value_next = {{(VALUE_W-ROOT_W){1'b0}}, root_reg};
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        step_reg  <= step_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== rtl/vector_norm_reducer.sv =====
// Vector norm reducer top level: mode register, front end, job queue, back end.
//
// Takes one signed Q8.16 element per cycle and reduces each vector to one
// scalar: L1 norm, L2 norm, infinity norm, minimum or maximum, chosen by the
// mode register (reset to L2). The front end takes an element every cycle
// through a square stage and a fold stage into the 64-bit accumulator. At the
// last element the finished accumulator enters a two-entry queue. The back end
// passes L1, infinity, minimum and maximum results straight to the output
// register, one per cycle while the output is free; an L2 result goes through
// the integer square root unit, which resolves two radicand bits per cycle.
// Input stalls only when the queue is full and another vector ends. Write
// mode only while no vector is in flight.
`default_nettype none

module vector_norm_reducer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vnr_pkg::MODE_W-1:0]          mode,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vnr_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vnr_pkg::VALUE_W-1:0]  value
);
    import vnr_pkg::*;

`include "assert_macros.svh"

    logic [MODE_W-1:0] mode_reg;
    logic              push;
    logic              pop;
    job_t              push_job;
    job_t              pop_job;
    q_status_t         q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_L2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= mode;
        end
    end

    vnr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .last     (last),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    vnr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    vnr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && q_status.full)
    `ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && q_status.empty)
    `ASSERT_IMPLY(a_stall_needs_full, clk, rst_n, !in_ready, q_status.full)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for vector_norm_reducer: streams vectors in every mode and checks each result.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vnr_pkg::*;

    localparam int RUN_LIMIT_NS    = 4_000_000;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SEGMENTS        = 6;
    localparam int SEGMENT_ITEMS   = 40;
    localparam int BURST_ITEMS     = 60;
    localparam int MAX_LENGTH      = 256;

    localparam logic [MODE_W-1:0]   MODE_SPARE_LO = MODE_MAX + 1'b1;
    localparam logic [MODE_W-1:0]   MODE_SPARE_HI = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN    = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE    = SAMPLE_W'(1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO   = '0;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1   = '1;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [MODE_W-1:0]          mode;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [VALUE_W-1:0]  value;

    logic [MODE_W-1:0]          mode_shadow;
    logic [ACC_W-1:0]           running_acc;
    bit                         vector_start;
    logic signed [VALUE_W-1:0]  pending_values[$];

    int                         send_idle_pct = 0;
    int                         stall_pct = 0;
    int                         errors = 0;
    logic                       receiver_held = 1'b0;
    event                       hold_off_start;

    vector_norm_reducer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .mode      (mode),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [ROOT_W-1:0] floor_root(input logic [ACC_W-1:0] n);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_W'(1) << b);
            if (ACC_W'(trial) * ACC_W'(trial) <= n)
                root = trial;
        end
        return root;
    endfunction

    task automatic fold_element(input logic [SAMPLE_W-1:0] s, input logic is_last);
        logic [ACC_W-1:0]   x;
        logic [ACC_W-1:0]   mag;
        logic [ACC_W-1:0]   sq;
        logic [ACC_W-1:0]   acc;
        logic [VALUE_W-1:0] result;
        x   = {{(ACC_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
        mag = s[SAMPLE_W-1] ? -x : x;
        acc = vector_start ? '0 : running_acc;
        case (mode_shadow)
            MODE_L1:
            begin
                if (acc > L1_LIMIT)
                    acc = L1_LIMIT;
                if (acc > L1_LIMIT - mag)
                    acc = L1_LIMIT;
                else
                    acc = acc + mag;
            end
            MODE_L2:
            begin
                sq = mag * mag;
                if (acc > ~sq)
                    acc = '1;
                else
                    acc = acc + sq;
            end
            MODE_LINF:
                if (vector_start || mag > acc)
                    acc = mag;
            MODE_MIN:
                if (vector_start || $signed(x) < $signed(acc))
                    acc = x;
            MODE_MAX:
                if (vector_start || $signed(x) > $signed(acc))
                    acc = x;
            default:
                acc = '0;
        endcase
        running_acc  = acc;
        vector_start = is_last;
        if (is_last)
        begin
            case (mode_shadow)
                MODE_L1:
                begin
                    if (acc > L1_LIMIT)
                        acc = L1_LIMIT;
                    result = acc[VALUE_W-1:0];
                end
                MODE_L2:
                    result = {{(VALUE_W - ROOT_W){1'b0}}, floor_root(acc)};
                MODE_LINF, MODE_MIN, MODE_MAX:
                    result = acc[VALUE_W-1:0];
                default:
                    result = '0;
            endcase
            pending_values.push_back(result);
        end
    endtask

    task automatic send_element(input logic [SAMPLE_W-1:0] s, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        fold_element(s, is_last);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        cfg_valid <= 1'b1;
        mode      <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0:
                return SAMPLE_W'($urandom_range(511) - 256);
            1:
                case ($urandom_range(3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return SAMPLE_ZERO;
                    default: return SAMPLE_NEG1;
                endcase
            default:
                return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic run_segment(input int budget, input bit leave_open);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(39) == 0)
                len = $urandom_range(MAX_LENGTH + 64, 9);
            else
                len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
                send_element(pick_sample(), k == len - 1);
            sent += len;
        end
        if (leave_open)
            repeat ($urandom_range(3, 1)) send_element(pick_sample(), 1'b0);
    endtask

    task automatic switch_mode_mid_vector(input logic [MODE_W-1:0] first_mode,
                                          input logic [SAMPLE_W-1:0] first_sample,
                                          input logic [MODE_W-1:0] final_mode,
                                          input logic [SAMPLE_W-1:0] final_sample);
        write_mode(first_mode);
        send_element(first_sample, 1'b0);
        drain();
        write_mode(final_mode);
        send_element(final_sample, 1'b1);
        drain();
    endtask

    task automatic test_reset_mode();
        send_element(SAMPLE_MAX, 1'b0);
        send_element(SAMPLE_MIN, 1'b1);
        send_element(SAMPLE_ZERO, 1'b1);
        drain();
    endtask

    task automatic test_each_mode();
        for (int m = MODE_L1; m <= MODE_MAX; m++)
        begin
            write_mode(MODE_W'(m));
            send_element(SAMPLE_MIN, 1'b0);
            send_element(SAMPLE_MAX, 1'b1);
            drain();
        end
    endtask

    task automatic test_spare_modes();
        write_mode(MODE_SPARE_LO);
        send_element(SAMPLE_MAX, 1'b1);
        drain();
        write_mode(MODE_SPARE_HI);
        send_element(SAMPLE_MIN, 1'b1);
        drain();
    endtask

    task automatic test_mode_switch_mid_vector();
        // a negative value left in the accumulator drives both saturations
        switch_mode_mid_vector(MODE_MIN, SAMPLE_NEG1, MODE_L2, SAMPLE_MAX);
        switch_mode_mid_vector(MODE_MIN, SAMPLE_MIN, MODE_L1, SAMPLE_MAX);
        switch_mode_mid_vector(MODE_L2, SAMPLE_MIN, MODE_MAX, SAMPLE_ONE);
        switch_mode_mid_vector(MODE_L1, SAMPLE_MAX, MODE_SPARE_HI, SAMPLE_MAX);
    endtask

    task automatic test_random_traffic(input int idle, input int stall);
        logic [MODE_W-1:0] m;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if ($urandom_range(7) == 0)
                m = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            else
                m = MODE_W'($urandom_range(MODE_MAX, MODE_L1));
            write_mode(m);
            run_segment(SEGMENT_ITEMS, $urandom_range(3) == 0);
            drain();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_output_backpressure();
        write_mode(MODE_L1);
        -> hold_off_start;
        for (int k = 0; k < BURST_ITEMS; k++)
            send_element(pick_sample(), 1'b1);
        drain();
    endtask

    always
    begin
        @(hold_off_start);
        receiver_held <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        receiver_held <= 1'b0;
    end

    always @(posedge clk)
        out_ready <= !receiver_held && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        logic signed [VALUE_W-1:0] wanted;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d",
                         $time, value);
                errors++;
            end
            else
            begin
                wanted = pending_values.pop_front();
                if (value !== wanted)
                begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, wanted, value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        mode         = MODE_L2;
        in_valid     = 1'b0;
        sample       = '0;
        last         = 1'b0;
        mode_shadow  = MODE_L2;
        running_acc  = '0;
        vector_start = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_mode();
        test_each_mode();
        test_spare_modes();
        test_mode_switch_mid_vector();
        test_random_traffic(0, 0);
        test_random_traffic(83, 0);
        test_random_traffic(0, 83);
        test_random_traffic(30, 30);
        test_output_backpressure();

        if (errors == 0 && pending_values.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/vnr_pkg.sv
rtl/vnr_front.sv
rtl/vnr_queue.sv
rtl/vnr_back.sv
rtl/vector_norm_reducer.sv
dv/tb.sv
